### src/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg: shared types and constants of the cylindrical volume sampler
// Item layout carried down the pipeline, fixed-point widths, register
// indexes and the arctangent table of the CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cvs_pkg;

    // Opcodes carried in s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT   = 2'd1;
    localparam logic [1:0] REG_SLICE_COUNT = 2'd2;

    // Geometry and arithmetic
    localparam int CORDIC_STEPS = 16;
    localparam int ADDR_W       = 17;
    localparam int X_W          = 27;   // CORDIC x/y datapath
    localparam int ANG_W        = 33;   // angle accumulator, Q.28 radians
    localparam int THETA_W      = 30;   // clamped angle 0..pi
    localparam int MAX_SPAN     = 13;   // slice_count - 2 at most
    localparam logic [29:0] PI_Q28 = 30'd843314857;
    localparam logic [22:0] ONE_Q22 = 23'd4194304;
    localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;

    typedef struct packed {
        logic        valid;
        logic        op;
        logic        in_bounds;
        logic        y_neg;
        logic [14:0] pos_z;
        logic [16:0] load_address;
        logic [7:0]  load_byte;
    } item_t;

    // atan(2^-i) in Q.28, rounded
    function automatic logic [27:0] atan_q28(input int idx);
        logic [27:0] v;
        case (idx)
            0:  v = 28'd210828714;
            1:  v = 28'd124459457;
            2:  v = 28'd65760959;
            3:  v = 28'd33381290;
            4:  v = 28'd16755422;
            5:  v = 28'd8385879;
            6:  v = 28'd4193963;
            7:  v = 28'd2097109;
            8:  v = 28'd1048571;
            9:  v = 28'd524287;
            10: v = 28'd262144;
            11: v = 28'd131072;
            12: v = 28'd65536;
            13: v = 28'd32768;
            14: v = 28'd16384;
            15: v = 28'd8192;
            16: v = 28'd4096;
            17: v = 28'd2048;
            18: v = 28'd1024;
            19: v = 28'd512;
            20: v = 28'd256;
            21: v = 28'd128;
            22: v = 28'd64;
            23: v = 28'd32;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/cvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// cvs_cordic_cell: one vectoring step of the CORDIC chain
// Rotates (x, y) toward the x axis by atan(2^-shift), accumulates the angle
// and hands the result and the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_cordic_cell (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire logic [4:0]                       shift,
    input  wire logic [27:0]                      atan,
    input  wire cvs_pkg::item_t                   item_in,
    input  wire logic signed [cvs_pkg::X_W-1:0]   x_in,
    input  wire logic signed [cvs_pkg::X_W-1:0]   y_in,
    input  wire logic signed [cvs_pkg::ANG_W-1:0] ang_in,
    output cvs_pkg::item_t                        item_out,
    output logic signed [cvs_pkg::X_W-1:0]        x_out,
    output logic signed [cvs_pkg::X_W-1:0]        y_out,
    output logic signed [cvs_pkg::ANG_W-1:0]      ang_out
);

    logic signed [cvs_pkg::X_W-1:0]   dx, dy;
    logic signed [cvs_pkg::ANG_W-1:0] da;
    logic signed [cvs_pkg::X_W-1:0]   x_next, y_next;
    logic signed [cvs_pkg::ANG_W-1:0] ang_next;
    cvs_pkg::item_t                   item_reg;
    logic signed [cvs_pkg::X_W-1:0]   x_reg, y_reg;
    logic signed [cvs_pkg::ANG_W-1:0] ang_reg;

    // Rotate by the sign of y
    always_comb begin
        dx = y_in >>> shift;
        dy = x_in >>> shift;
        da = $signed({{(cvs_pkg::ANG_W-28){1'b0}}, atan});
        if (!y_in[cvs_pkg::X_W-1]) begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            ang_next = ang_in + da;
        end else begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            ang_next = ang_in - da;
        end
    end

    // Hand off to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
        end else if (en) begin
            item_reg <= item_in;
        end
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign item_out = item_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign ang_out  = ang_reg;

endmodule

`default_nettype wire

### src/cvs_post.sv
// ----------------------------------------------------------------------------
// cvs_post: radius scaling and voxel address generation
// Five stages: gain correction, half-plane fold, index products, slice
// search, address sum. Load beats pass their own address through.
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_post (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire logic [7:0]                       row_bytes,
    input  wire logic [7:0]                       row_count,
    input  wire logic [3:0]                       slice_count,
    input  wire cvs_pkg::item_t                   item_in,
    input  wire logic signed [cvs_pkg::X_W-1:0]   x_in,
    input  wire logic signed [cvs_pkg::ANG_W-1:0] ang_in,
    output cvs_pkg::item_t                        item_out,
    output logic [cvs_pkg::ADDR_W-1:0]            addr_out
);

    // Stage A: radius times inverse gain
    logic signed [43:0]                 prod_a;
    logic signed [43:0]                 r_full;
    logic [22:0]                        r_next;
    cvs_pkg::item_t                     item_a_reg;
    logic [22:0]                        r_reg;
    logic signed [cvs_pkg::ANG_W-1:0]   ang_a_reg;

    always_comb begin
        prod_a = 44'(x_in) * $signed({27'd0, cvs_pkg::INV_GAIN_Q16});
        r_full = prod_a >>> 16;
        if (r_full < 0) begin
            r_next = '0;
        end else if (r_full > $signed({21'd0, cvs_pkg::ONE_Q22})) begin
            r_next = cvs_pkg::ONE_Q22;
        end else begin
            r_next = r_full[22:0];
        end
    end

    // Stage B: fold lower half plane, clamp angle
    logic signed [cvs_pkg::ANG_W-1:0]   theta_b;
    logic [23:0]                        rsum_b;
    logic [22:0]                        rp_next;
    logic [cvs_pkg::THETA_W-1:0]        theta_next;
    cvs_pkg::item_t                     item_b_reg;
    logic [22:0]                        rp_reg;
    logic [cvs_pkg::THETA_W-1:0]        theta_reg;

    always_comb begin
        if (item_a_reg.y_neg) begin
            theta_b = ang_a_reg + $signed({3'd0, cvs_pkg::PI_Q28});
            rsum_b  = {1'b0, cvs_pkg::ONE_Q22} - {1'b0, r_reg};
        end else begin
            theta_b = ang_a_reg;
            rsum_b  = {1'b0, cvs_pkg::ONE_Q22} + {1'b0, r_reg};
        end
        rp_next = rsum_b[23:1];
        if (theta_b < 0) begin
            theta_next = '0;
        end else if (theta_b > $signed({3'd0, cvs_pkg::PI_Q28})) begin
            theta_next = cvs_pkg::PI_Q28;
        end else begin
            theta_next = theta_b[cvs_pkg::THETA_W-1:0];
        end
    end

    // Stage C: column, row and angle-span products
    logic [7:0]  col_scale;
    logic [30:0] col_prod;
    logic [22:0] row_prod;
    logic [8:0]  row_raw;
    logic [7:0]  row_next;
    logic [3:0]  span;
    logic [33:0] tspan_next;
    cvs_pkg::item_t item_c_reg;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [33:0] tspan_reg;

    always_comb begin
        col_scale  = (row_bytes != 8'd0) ? row_bytes - 8'd1 : 8'd0;
        col_prod   = 31'(rp_reg) * 31'(col_scale);
        row_prod   = 23'(item_b_reg.pos_z) * 23'(row_count);
        row_raw    = row_prod[22:14];
        if (row_count == 8'd0) begin
            row_next = '0;
        end else if (row_raw > 9'(row_count - 8'd1)) begin
            row_next = row_count - 8'd1;
        end else begin
            row_next = row_raw[7:0];
        end
        span       = (slice_count > 4'd2) ? slice_count - 4'd2 : 4'd0;
        tspan_next = 34'(theta_reg) * 34'(span);
    end

    // Stage D: slice by comparing against multiples of pi
    logic [3:0]  slice_next;
    logic [15:0] rowoff_next;
    cvs_pkg::item_t item_d_reg;
    logic [7:0]  col_d_reg;
    logic [3:0]  slice_reg;
    logic [15:0] rowoff_reg;

    always_comb begin
        slice_next = '0;
        for (int k = 1; k <= cvs_pkg::MAX_SPAN; k++) begin
            if (tspan_reg >= 34'(k) * 34'(cvs_pkg::PI_Q28)) begin
                slice_next = 4'(k);
            end
        end
        rowoff_next = 16'(row_reg) * 16'(row_bytes);
    end

    // Stage E: address sum, or the load address as given
    logic [cvs_pkg::ADDR_W-1:0] addr_next;
    cvs_pkg::item_t             item_e_reg;
    logic [cvs_pkg::ADDR_W-1:0] addr_reg;

    always_comb begin
        if (item_d_reg.op == cvs_pkg::OP_LOAD) begin
            addr_next = item_d_reg.load_address;
        end else begin
            addr_next = {slice_reg[2:0], 14'd0} + 17'(rowoff_reg) + 17'(col_d_reg);
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_a_reg <= '0;
            item_b_reg <= '0;
            item_c_reg <= '0;
            item_d_reg <= '0;
            item_e_reg <= '0;
        end else if (en) begin
            item_a_reg <= item_in;
            item_b_reg <= item_a_reg;
            item_c_reg <= item_b_reg;
            item_d_reg <= item_c_reg;
            item_e_reg <= item_d_reg;
        end
        if (en) begin
            r_reg      <= r_next;
            ang_a_reg  <= ang_in;
            rp_reg     <= rp_next;
            theta_reg  <= theta_next;
            col_reg    <= col_prod[29:22];
            row_reg    <= row_next;
            tspan_reg  <= tspan_next;
            col_d_reg  <= col_reg;
            slice_reg  <= slice_next;
            rowoff_reg <= rowoff_next;
            addr_reg   <= addr_next;
        end
    end

    assign item_out = item_e_reg;
    assign addr_out = addr_reg;

endmodule

`default_nettype wire

### src/cylindrical_volume_sampler.sv
// ----------------------------------------------------------------------------
// cylindrical_volume_sampler: polar-to-Cartesian scan conversion top level
// Takes one beat per cycle unless a result beat is held. A load beat writes
// one byte of the 128 KiB voxel store; a sample beat returns one result beat
// after one input register, a chain of 16 CORDIC cells, five address stages
// and the store read, of which the CORDIC chain is the deepest part. The
// single-port store takes one access per cycle, so throughput is one beat per
// cycle whenever the result side is ready. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cylindrical_volume_sampler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // pos_x, pos_y, pos_z, load_address, load_byte
    input  wire logic        s_tuser,   // opcode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // sample
    output logic             m_tuser    // inside_res
);

    localparam int N = cvs_pkg::CORDIC_STEPS;

    logic       en;
    logic [7:0] row_bytes_reg;
    logic [7:0] row_count_reg;
    logic [3:0] slice_count_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg   <= 8'd128;
            row_count_reg   <= 8'd128;
            slice_count_reg <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                cvs_pkg::REG_ROW_BYTES:   row_bytes_reg   <= cfg_wdata;
                cvs_pkg::REG_ROW_COUNT:   row_count_reg   <= cfg_wdata;
                cvs_pkg::REG_SLICE_COUNT: slice_count_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless a result beat is held
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Input stage: bounds test and half-plane move
    logic signed [15:0] px, py, pz;
    logic signed [31:0] sqx, sqy;
    logic [32:0]        sqsum;
    logic signed [cvs_pkg::X_W-1:0]   x0_next, y0_next;
    logic signed [cvs_pkg::ANG_W-1:0] a0_next;
    cvs_pkg::item_t     item0_next;

    always_comb begin
        px    = s_tdata[15:0];
        py    = s_tdata[31:16];
        pz    = s_tdata[47:32];
        sqx   = 32'(px) * 32'(px);
        sqy   = 32'(py) * 32'(py);
        sqsum = 33'(unsigned'(sqx)) + 33'(unsigned'(sqy));
        if (px[15]) begin
            x0_next = -(27'(px) <<< 8);
            y0_next = -(27'(py) <<< 8);
            a0_next = py[15] ? -$signed({3'd0, cvs_pkg::PI_Q28})
                             :  $signed({3'd0, cvs_pkg::PI_Q28});
        end else begin
            x0_next = 27'(px) <<< 8;
            y0_next = 27'(py) <<< 8;
            a0_next = '0;
        end
        item0_next.valid        = s_tvalid;
        item0_next.op           = s_tuser;
        item0_next.in_bounds    = !pz[15] && (pz <= 16'sd16384)
                                  && (sqsum <= 33'h010000000);
        item0_next.y_neg        = py[15];
        item0_next.pos_z        = pz[14:0];
        item0_next.load_address = s_tdata[64:48];
        item0_next.load_byte    = s_tdata[72:65];
    end

    cvs_pkg::item_t                   item_c [0:N];
    logic signed [cvs_pkg::X_W-1:0]   x_c    [0:N];
    logic signed [cvs_pkg::X_W-1:0]   y_c    [0:N];
    logic signed [cvs_pkg::ANG_W-1:0] a_c    [0:N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_c[0] <= '0;
        end else if (en) begin
            item_c[0] <= item0_next;
        end
        if (en) begin
            x_c[0] <= x0_next;
            y_c[0] <= y0_next;
            a_c[0] <= a0_next;
        end
    end

    // CORDIC chain
    for (genvar i = 0; i < N; i++) begin : g_cell
        cvs_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .shift    (5'(i)),
            .atan     (cvs_pkg::atan_q28(i)),
            .item_in  (item_c[i]),
            .x_in     (x_c[i]),
            .y_in     (y_c[i]),
            .ang_in   (a_c[i]),
            .item_out (item_c[i+1]),
            .x_out    (x_c[i+1]),
            .y_out    (y_c[i+1]),
            .ang_out  (a_c[i+1])
        );
    end

    // Address generation
    cvs_pkg::item_t             item_p;
    logic [cvs_pkg::ADDR_W-1:0] addr_p;

    cvs_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .row_bytes   (row_bytes_reg),
        .row_count   (row_count_reg),
        .slice_count (slice_count_reg),
        .item_in     (item_c[N]),
        .x_in        (x_c[N]),
        .ang_in      (a_c[N]),
        .item_out    (item_p),
        .addr_out    (addr_p)
    );

    // Voxel store: write on load beats, registered read on sample beats
    logic [7:0] voxel_mem [0:(1<<cvs_pkg::ADDR_W)-1];
    logic [7:0] rdata_reg;
    logic       inside_reg;

    always_ff @(posedge aclk) begin
        if (en && item_p.valid) begin
            if (item_p.op == cvs_pkg::OP_LOAD) begin
                voxel_mem[addr_p] <= item_p.load_byte;
            end else begin
                rdata_reg <= voxel_mem[addr_p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= item_p.valid && (item_p.op == cvs_pkg::OP_SAMPLE);
        end
        if (en) begin
            inside_reg <= item_p.in_bounds;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = inside_reg;
    assign m_tdata  = inside_reg ? rdata_reg : 8'd0;

endmodule

`default_nettype wire
